// ----- design/tli_pkg.sv -----
// Shared types and constants for the table linear interpolator.
`default_nettype none
package tli_pkg;

	// Default table depth.
	localparam int MAX_POINTS_DEF = 64;

	// Item operation codes.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_IN    = 2'd0,
		ST_BELOW = 2'd1,
		ST_ABOVE = 2'd2
	} status_t;

	// One input item.
	typedef struct packed {
		logic               op;
		logic [5:0]         entry_index;
		logic [31:0]        pressure_value;
		logic signed [31:0] entry_fvf;
		logic signed [31:0] entry_weight;
		logic signed [31:0] entry_viscosity;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic signed [31:0] fvf_out;
		logic signed [31:0] weight_out;
		logic signed [31:0] viscosity_out;
		status_t            status;
	} out_item_t;

	// Classified command passed from the front to the back.
	typedef struct packed {
		logic     is_query;
		logic     write_ok;
		in_item_t item;
	} cmd_t;

	// One stored table point.
	typedef struct packed {
		logic [31:0] p;
		logic [31:0] f;
		logic [31:0] w;
		logic [31:0] v;
	} row_t;

endpackage
`default_nettype wire

// ----- design/table_linear_interpolator.sv -----
// Top level: piecewise-linear table interpolator with queue-style ports.
// A write item updates the table when the back end takes it from the input queue.
// A query first searches the table linearly for its segment; for a segment of nonzero width,
// each column then runs 33 multiply and 33 divide steps in the shared unit. One item is
// worked at a time; two-entry queues sit at the input and the output. Reset (arst_n,
// asynchronous, low) empties both queues and sets point_count to 2.
`default_nettype none
module table_linear_interpolator #(
	parameter int MAX_POINTS = tli_pkg::MAX_POINTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire tli_pkg::in_item_t  in_item,
	output logic                    full,
	output tli_pkg::out_item_t      out_item,
	output logic                    empty,
	input  wire logic               pop,
	input  wire logic               cfg_we,
	input  wire logic [6:0]         cfg_data
);
	import tli_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);

	logic [6:0]    point_count_q;
	logic [31:0]   pc_ext;
	logic [31:0]   n_used;
	logic [31:0]   n_last_w;
	logic [AW-1:0] n_last;
	cmd_t          cmd;
	logic          cmd_empty;
	logic          cmd_pop;
	logic          res_push;
	out_item_t     res;
	logic          res_full;

	// Point count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) point_count_q <= 7'd2;
		else if (cfg_we) point_count_q <= cfg_data;
	end

	// Clamp the point count to between 2 and the table depth.
	always_comb begin
		pc_ext = 32'(point_count_q);
		if (pc_ext < 32'd2) n_used = 32'd2;
		else if (pc_ext > 32'(MAX_POINTS)) n_used = 32'(MAX_POINTS);
		else n_used = pc_ext;
		n_last_w = n_used - 32'd1;
		n_last   = n_last_w[AW-1:0];
	end

	tli_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.in_item  (in_item),
		.full     (full),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.cmd_empty(cmd_empty)
	);

	tli_back #(.MAX_POINTS(MAX_POINTS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.n_last   (n_last),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full)
	);

	tli_fifo #(.T(out_item_t)) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (out_item),
		.empty (empty)
	);
endmodule
`default_nettype wire

// ----- design/tli_fifo.sv -----
// Two-entry first-in first-out queue for any packed item type.
`default_nettype none
module tli_fifo #(
	parameter type T = logic
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire T     wdata,
	output logic      full,
	input  wire logic pop,
	output T          rdata,
	output logic      empty
);
	T           mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	// Item storage.
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end
endmodule
`default_nettype wire

// ----- design/tli_front.sv -----
// Front end: accepts items, classifies them and queues them for the back end.
`default_nettype none
module tli_front #(
	parameter int MAX_POINTS = tli_pkg::MAX_POINTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire tli_pkg::in_item_t in_item,
	output logic                   full,
	input  wire logic              cmd_pop,
	output tli_pkg::cmd_t          cmd,
	output logic                   cmd_empty
);
	import tli_pkg::*;

	cmd_t        cls;
	logic [31:0] idx_ext;

	// Classify the item and check the write index against the table depth.
	always_comb begin
		idx_ext      = 32'(in_item.entry_index);
		cls.is_query = (in_item.op == OP_QUERY);
		cls.write_ok = (idx_ext < 32'(MAX_POINTS));
		cls.item     = in_item;
	end

	tli_fifo #(.T(cmd_t)) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cls),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd),
		.empty (cmd_empty)
	);
endmodule
`default_nettype wire

// ----- design/tli_muldiv.sv -----
// Shift-add multiplier followed by restoring divider: quot = mag * dp / dw.
`default_nettype none
module tli_muldiv (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [32:0] mag,
	input  wire logic [31:0] dp,
	input  wire logic [31:0] dw,
	output logic             done,
	output logic [32:0]      quot
);
	import tli_pkg::*;

	typedef enum logic [2:0] {
		M_IDLE = 3'b001,
		M_MUL  = 3'b010,
		M_DIV  = 3'b100
	} mstate_t;

	mstate_t     state_q;
	logic [5:0]  cnt_q;
	logic [31:0] hi_q;
	logic [32:0] lo_q;
	logic [31:0] dp_q;
	logic [31:0] dw_q;
	logic [32:0] add_sum;
	logic [32:0] rem_sh;
	logic [32:0] rem_sub;
	logic        fits;

	// One multiply step and one divide step.
	always_comb begin
		add_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, dp_q} : 33'd0);
		rem_sh  = {hi_q, lo_q[32]};
		rem_sub = rem_sh - {1'b0, dw_q};
		fits    = (rem_sh >= {1'b0, dw_q});
	end

	assign quot = lo_q;

	// The product lands in {hi, lo}; the divider then shifts the quotient into lo.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= 6'd0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= M_MUL;
						cnt_q   <= 6'd0;
					end
				end
				M_MUL: begin
					if (cnt_q == 6'd32) begin
						state_q <= M_DIV;
						cnt_q   <= 6'd0;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				M_DIV: begin
					if (cnt_q == 6'd32) begin
						state_q <= M_IDLE;
						done    <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			M_IDLE: begin
				if (start) begin
					hi_q <= 32'd0;
					lo_q <= mag;
					dp_q <= dp;
					dw_q <= dw;
				end
			end
			M_MUL: begin
				hi_q <= add_sum[32:1];
				lo_q <= {add_sum[0], lo_q[32:1]};
			end
			M_DIV: begin
				hi_q <= fits ? rem_sub[31:0] : rem_sh[31:0];
				lo_q <= {lo_q[31:0], fits};
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ----- design/tli_back.sv -----
// Back end: table memory, segment search and per-column interpolation.
`default_nettype none
module tli_back #(
	parameter int MAX_POINTS = tli_pkg::MAX_POINTS_DEF,
	localparam int AW = $clog2(MAX_POINTS)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [AW-1:0]  n_last,
	input  wire tli_pkg::cmd_t  cmd,
	input  wire logic           cmd_empty,
	output logic                cmd_pop,
	output logic                res_push,
	output tli_pkg::out_item_t  res,
	input  wire logic           res_full
);
	import tli_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CHKLO = 7'b0000010,
		S_CHKHI = 7'b0000100,
		S_SCAN  = 7'b0001000,
		S_START = 7'b0010000,
		S_WAIT  = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	row_t          mem [MAX_POINTS];
	row_t          rd_row_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic          wr_en;
	row_t          wr_row;
	logic [31:0]   idx_ext;

	state_t        state_q;
	logic [31:0]   p_q;
	logic [AW-1:0] i_q;
	row_t          lo_q;
	row_t          hi_q;
	logic [31:0]   dp_q;
	logic [31:0]   dw_q;
	logic [1:0]    col_q;
	logic          neg_q;
	logic [31:0]   lo_val_q;
	out_item_t     res_q;

	logic [31:0]   col_lo;
	logic [31:0]   col_hi;
	logic [32:0]   dv;
	logic [32:0]   mag;
	logic          md_start;
	logic          md_done;
	logic [32:0]   md_quot;
	logic [31:0]   col_res;

	// Memory ports.
	always_comb begin
		idx_ext  = 32'(cmd.item.entry_index);
		wr_addr  = idx_ext[AW-1:0];
		wr_row.p = cmd.item.pressure_value;
		wr_row.f = cmd.item.entry_fvf;
		wr_row.w = cmd.item.entry_weight;
		wr_row.v = cmd.item.entry_viscosity;
		wr_en    = (state_q == S_IDLE) && !cmd_empty && !cmd.is_query && cmd.write_ok;
		case (state_q)
			S_CHKLO: rd_addr = n_last;
			S_SCAN:  rd_addr = i_q + AW'(1);
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_row;
		rd_row_q <= mem[rd_addr];
	end

	// Column select and property step.
	always_comb begin
		case (col_q)
			2'd0:    begin col_lo = lo_q.f; col_hi = hi_q.f; end
			2'd1:    begin col_lo = lo_q.w; col_hi = hi_q.w; end
			default: begin col_lo = lo_q.v; col_hi = hi_q.v; end
		endcase
		dv       = {col_hi[31], col_hi} - {col_lo[31], col_lo};
		mag      = dv[32] ? (33'd0 - dv) : dv;
		md_start = (state_q == S_START) && (dw_q != 32'd0);
		col_res  = neg_q ? (lo_val_q - md_quot[31:0]) : (lo_val_q + md_quot[31:0]);
	end

	tli_muldiv u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (md_start),
		.mag   (mag),
		.dp    (dp_q),
		.dw    (dw_q),
		.done  (md_done),
		.quot  (md_quot)
	);

	assign cmd_pop  = (state_q == S_IDLE) && !cmd_empty;
	assign res_push = (state_q == S_OUT);
	assign res      = res_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!cmd_empty && cmd.is_query) state_q <= S_CHKLO;
				end
				S_CHKLO: begin
					state_q <= (p_q < rd_row_q.p) ? S_OUT : S_CHKHI;
				end
				S_CHKHI: begin
					state_q <= (p_q > rd_row_q.p) ? S_OUT : S_SCAN;
				end
				S_SCAN: begin
					if (!(i_q < n_last && p_q > rd_row_q.p)) begin
						state_q <= (i_q == '0) ? S_OUT : S_START;
					end
				end
				S_START: begin
					if (dw_q != 32'd0) state_q <= S_WAIT;
					else if (col_q == 2'd2) state_q <= S_OUT;
				end
				S_WAIT: begin
					if (md_done) state_q <= (col_q == 2'd2) ? S_OUT : S_START;
				end
				S_OUT: begin
					if (!res_full) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Query datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				p_q <= cmd.item.pressure_value;
			end
			S_CHKLO: begin
				res_q.fvf_out       <= '0;
				res_q.weight_out    <= '0;
				res_q.viscosity_out <= '0;
				res_q.status        <= (p_q < rd_row_q.p) ? ST_BELOW : ST_IN;
			end
			S_CHKHI: begin
				if (p_q > rd_row_q.p) res_q.status <= ST_ABOVE;
				i_q <= '0;
			end
			S_SCAN: begin
				if (i_q < n_last && p_q > rd_row_q.p) begin
					lo_q <= rd_row_q;
					i_q  <= i_q + AW'(1);
				end else begin
					hi_q  <= rd_row_q;
					dp_q  <= p_q - lo_q.p;
					dw_q  <= rd_row_q.p - lo_q.p;
					col_q <= 2'd0;
					if (i_q == '0) begin
						res_q.fvf_out       <= rd_row_q.f;
						res_q.weight_out    <= rd_row_q.w;
						res_q.viscosity_out <= rd_row_q.v;
					end
				end
			end
			S_START: begin
				neg_q    <= dv[32];
				lo_val_q <= col_lo;
				// A zero-width segment keeps the lower value.
				if (dw_q == 32'd0) begin
					case (col_q)
						2'd0:    res_q.fvf_out       <= col_lo;
						2'd1:    res_q.weight_out    <= col_lo;
						default: res_q.viscosity_out <= col_lo;
					endcase
					col_q <= col_q + 2'd1;
				end
			end
			S_WAIT: begin
				if (md_done) begin
					case (col_q)
						2'd0:    res_q.fvf_out       <= col_res;
						2'd1:    res_q.weight_out    <= col_res;
						default: res_q.viscosity_out <= col_res;
					endcase
					col_q <= col_q + 2'd1;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for the table linear interpolator: table writes, queries and checked results.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import tli_pkg::*;

	localparam int DEPTH = 64;
	localparam int SETTLE_CYCLES = 300;
	localparam longint CYCLE_LIMIT = 3000000;

	// Shadow of the interpolator: table, point count and the results still owed.
	class interp_scoreboard;
		logic [31:0] ptab [DEPTH];
		logic [31:0] ftab [DEPTH];
		logic [31:0] wtab [DEPTH];
		logic [31:0] vtab [DEPTH];
		logic [6:0]  point_count;
		out_item_t   owed [$];
		int          errors;

		function new();
			point_count = 7'd2;
			errors = 0;
		endfunction

		// Point count as the block uses it, clamped to the table.
		function int used_points();
			int n;
			n = int'(point_count);
			if (n < 2) n = 2;
			if (n > DEPTH) n = DEPTH;
			return n;
		endfunction

		// lo + trunc(dp * (hi - lo) / dw), truncated toward zero.
		function logic [31:0] blend(logic [31:0] lo_raw, logic [31:0] hi_raw,
				logic [31:0] dp, logic [31:0] dw);
			longint lo, hi, dv, r;
			longint unsigned mag, q;
			lo = longint'($signed(lo_raw));
			hi = longint'($signed(hi_raw));
			dv = hi - lo;
			if (dw == 32'd0) return lo_raw;
			mag = (dv < 0) ? longint'(-dv) : dv;
			q = (mag * {32'd0, dp}) / {32'd0, dw};
			r = (dv < 0) ? lo - longint'(q) : lo + longint'(q);
			return r[31:0];
		endfunction

		// Note an accepted item: writes update the table, queries owe one result.
		function void note_item(in_item_t it);
			out_item_t res;
			int n, i;
			logic [31:0] p, dp, dw;
			p = it.pressure_value;
			if (it.op == OP_WRITE) begin
				ptab[it.entry_index] = it.pressure_value;
				ftab[it.entry_index] = it.entry_fvf;
				wtab[it.entry_index] = it.entry_weight;
				vtab[it.entry_index] = it.entry_viscosity;
				return;
			end
			n = used_points();
			res.fvf_out = '0;
			res.weight_out = '0;
			res.viscosity_out = '0;
			if (p < ptab[0]) begin
				res.status = ST_BELOW;
			end else if (p > ptab[n-1]) begin
				res.status = ST_ABOVE;
			end else begin
				res.status = ST_IN;
				i = 0;
				while (i < n - 1 && p > ptab[i]) i++;
				if (i == 0) begin
					res.fvf_out = ftab[0];
					res.weight_out = wtab[0];
					res.viscosity_out = vtab[0];
				end else begin
					dp = p - ptab[i-1];
					dw = ptab[i] - ptab[i-1];
					res.fvf_out = blend(ftab[i-1], ftab[i], dp, dw);
					res.weight_out = blend(wtab[i-1], wtab[i], dp, dw);
					res.viscosity_out = blend(vtab[i-1], vtab[i], dp, dw);
				end
			end
			owed.push_back(res);
		endfunction

		// Compare one popped result with the oldest one owed.
		function void check_result(out_item_t got);
			out_item_t want;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result, actual %h", $time, got);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (got.fvf_out !== want.fvf_out) begin
				$display("%0t: fvf_out expected %h actual %h", $time, want.fvf_out, got.fvf_out);
				errors++;
			end
			if (got.weight_out !== want.weight_out) begin
				$display("%0t: weight_out expected %h actual %h", $time,
					want.weight_out, got.weight_out);
				errors++;
			end
			if (got.viscosity_out !== want.viscosity_out) begin
				$display("%0t: viscosity_out expected %h actual %h", $time,
					want.viscosity_out, got.viscosity_out);
				errors++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      push;
	in_item_t  in_item;
	logic      full;
	out_item_t out_item;
	logic      empty;
	logic      pop;
	logic      cfg_we;
	logic [6:0] cfg_data;

	interp_scoreboard sb;
	longint cycles;
	bit     quiet;

	table_linear_interpolator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.in_item  (in_item),
		.full     (full),
		.out_item (out_item),
		.empty    (empty),
		.pop      (pop),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// Clock, 4 ns period.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run limit.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: random stall bursts, checks on every accepted result.
	initial begin : result_side
		int stall;
		stall = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(1, 15) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
			@(posedge clk);
			if (pop && !empty) sb.check_result(out_item);
		end
	end

	// Offer one item and hold it until it is accepted; ends at a falling edge.
	task automatic send_item(in_item_t it);
		push <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (full);
		sb.note_item(it);
		@(negedge clk);
	endtask

	// Input-side gap of the given number of cycles.
	task automatic input_gap(int k);
		push <= 1'b0;
		repeat (k) @(negedge clk);
	endtask

	// Random gap now and then, none in the quiet stretch.
	task automatic maybe_gap();
		if (!quiet && $urandom_range(0, 7) == 0) input_gap($urandom_range(1, 15));
	endtask

	task automatic write_point(int idx, logic [31:0] p, logic [31:0] f, logic [31:0] w,
			logic [31:0] v);
		in_item_t it;
		it.op = OP_WRITE;
		it.entry_index = idx[5:0];
		it.pressure_value = p;
		it.entry_fvf = f;
		it.entry_weight = w;
		it.entry_viscosity = v;
		send_item(it);
		maybe_gap();
	endtask

	task automatic query(logic [31:0] p);
		in_item_t it;
		it.op = OP_QUERY;
		it.entry_index = 6'($urandom);
		it.pressure_value = p;
		it.entry_fvf = $urandom;
		it.entry_weight = $urandom;
		it.entry_viscosity = $urandom;
		send_item(it);
		maybe_gap();
	endtask

	// Wait for every owed result, then let the block settle.
	task automatic drain();
		push <= 1'b0;
		while (sb.owed.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_points(logic [6:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		sb.point_count = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Write a full table sorted by rising pressure between lo and hi.
	task automatic load_sorted(logic [31:0] lo, logic [31:0] hi);
		logic [31:0] ps [DEPTH];
		foreach (ps[i]) ps[i] = $urandom;
		ps.sort();
		ps[0] = lo;
		ps[DEPTH-1] = hi;
		for (int i = 1; i < DEPTH - 1; i++) begin
			if (ps[i] < lo) ps[i] = lo;
			if (ps[i] > hi) ps[i] = hi;
		end
		foreach (ps[i]) write_point(i, ps[i], $urandom, $urandom, $urandom);
	endtask

	// Query pressure: mostly inside the used range, some exact points and edges.
	function automatic logic [31:0] pick_pressure();
		int n, k;
		logic [31:0] lo, hi;
		n = sb.used_points();
		lo = sb.ptab[0];
		hi = sb.ptab[n-1];
		k = $urandom_range(0, 99);
		if (k < 60) return lo + $urandom_range(0, hi - lo);
		if (k < 80) return sb.ptab[$urandom_range(0, n - 1)];
		if (k < 86) return lo - 1;
		if (k < 92) return hi + 1;
		return $urandom;
	endfunction

	// Stimulus.
	initial begin : stimulus
		logic [6:0] counts [8];
		sb = new();
		quiet = 1'b0;
		push = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_data = 7'd0;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		counts = '{7'd64, 7'd2, 7'd0, 7'd127, 7'd64, 7'd1, 7'd33, 7'd0};
		counts[7] = 7'($urandom_range(2, 64));

		// Directed: full table, extreme neighbouring values, edges of the range.
		set_points(7'd64);
		load_sorted(32'h0000_0100, 32'hFFFF_0000);
		write_point(1, sb.ptab[1], 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
		write_point(2, sb.ptab[1] + 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		query(32'h0);
		query(32'h0000_00FF);
		query(32'h0000_0100);
		query(32'h0000_0101);
		query(sb.ptab[1] + 32'h8000);
		query(sb.ptab[1]);
		query(sb.ptab[2]);
		query(32'hFFFF_0000);
		query(32'hFFFF_0001);
		query(32'hFFFF_FFFF);

		// Phases at several point counts, each on a fresh sorted table.
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			set_points(counts[ph]);
			if (ph == 7) quiet = 1'b1;
			if (ph == 4) load_sorted(32'h0, 32'hFFFF_FFFF);
			else load_sorted($urandom_range(1, 32'h00FF_FFFF), $urandom_range(32'hFF00_0000,
				32'hFFFF_FFFE));
			for (int j = 0; j < 140; j++) begin
				if ($urandom_range(0, 9) == 0)
					write_point($urandom_range(0, DEPTH - 1), $urandom, $urandom, $urandom,
						$urandom);
				else
					query(pick_pressure());
			end
		end

		// Wait out the last results, then report.
		drain();
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire
